/* rtl/pgse_pkg.sv */
// Shared types, constants and helper functions for the grayscale PNG encoder.
// No dependencies; imported by the front, the sequencer and the top level.
`timescale 1ns / 1ps
package pgse_pkg;

	localparam int DIM_W = 13;
	localparam int RAW_W = 26;

	// command passed from the front to the byte sequencer
	typedef struct packed {
		logic [7:0]       pix;
		logic             first;
		logic             col0;
		logic             last;
		logic             tail;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
	} cmd_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       eoi;
	} obyte_t;

	localparam int CMD_W  = $bits(cmd_t);
	localparam int OBYTE_W = $bits(obyte_t);

	localparam logic [16:0] ADLER_MOD = 17'd65521;
	localparam logic [15:0] BLOCK_MAX = 16'hFFFF;
	localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
	localparam logic [5:0]  RUN_LAST  = 6'd59;

	// file header layout (signature .. zlib header)
	localparam logic [5:0] HDR_IHDR_TYPE = 6'd12;
	localparam logic [5:0] HDR_IHDR_END  = 6'd28;
	localparam logic [5:0] HDR_CRC0      = 6'd29;
	localparam logic [5:0] HDR_LEN0      = 6'd33;
	localparam logic [5:0] HDR_IDAT_TYPE = 6'd37;
	localparam logic [5:0] HDR_LAST      = 6'd42;

	// trailer layout (Adler, IDAT CRC, IEND chunk)
	localparam logic [4:0] TL_CRC0      = 5'd4;
	localparam logic [4:0] TL_IEND_LEN  = 5'd8;
	localparam logic [4:0] TL_IEND_TYPE = 5'd12;
	localparam logic [4:0] TL_CRC1      = 5'd16;
	localparam logic [4:0] TL_LAST      = 5'd19;

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++)
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		return r;
	endfunction

	// fixed header bytes; positions filled at run time return zero
	function automatic logic [7:0] hdr_const(input logic [5:0] i);
		logic [7:0] v;
		unique case (i)
			6'd0:  v = 8'd137;
			6'd1:  v = 8'h50;
			6'd2:  v = 8'h4E;
			6'd3:  v = 8'h47;
			6'd4:  v = 8'h0D;
			6'd5:  v = 8'h0A;
			6'd6:  v = 8'h1A;
			6'd7:  v = 8'h0A;
			6'd11: v = 8'd13;
			6'd12: v = 8'h49;
			6'd13: v = 8'h48;
			6'd14: v = 8'h44;
			6'd15: v = 8'h52;
			6'd24: v = 8'd8;
			6'd37: v = 8'h49;
			6'd38: v = 8'h44;
			6'd39: v = 8'h41;
			6'd40: v = 8'h54;
			6'd41: v = 8'h78;
			6'd42: v = 8'h01;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] iend_type(input logic [1:0] i);
		logic [7:0] v;
		unique case (i)
			2'd0: v = 8'h49;
			2'd1: v = 8'h45;
			2'd2: v = 8'h4E;
			default: v = 8'h44;
		endcase
		return v;
	endfunction

endpackage

/* rtl/png_gray_stored_encoder_top.sv */
// Top level of the grayscale PNG encoder with stored deflate blocks.
// Instantiates pgse_front, pgse_fifo (command and output queues) and pgse_back.
`timescale 1ns / 1ps
// Push 8-bit gray pixels in raster order; pop the PNG file one byte a transfer.
// Width and height are sampled at the first pixel of an image. The first pixel
// produces the 43-byte file header followed by a 5-byte stored block header,
// the row filter byte and the pixel; an ordinary pixel costs a command fetch
// plus one byte through the sequencer, a row start one byte more, and each new
// stored block 5 bytes more. The last pixel adds 20 trailer bytes. The sequencer
// sets the throughput: it idles to fetch each command, then one byte per cycle
// while the output queue has room. After the last byte (end_of_image), pixels
// are dropped until reset; a 1x1 image's last 10 bytes come on the next pixel.
module png_gray_stored_encoder_top #(
	parameter int MAX_WIDTH = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  pixel,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        last_of_run,
	output logic        end_of_image
);
	import pgse_pkg::*;

	cmd_t   fcmd, bcmd;
	obyte_t bitem, oitem;
	logic   enq, cq_empty, cq_pop, ob_full, ob_push;
	logic [CMD_W-1:0]   bcmd_bits;
	logic [OBYTE_W-1:0] oitem_bits;

	pgse_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.accept(push && !full), .pixel, .enq, .cmd(fcmd)
	);

	pgse_fifo #(.W(CMD_W), .DEPTH(4)) u_cq (
		.clk, .arst_n, .push(enq), .wdata(fcmd), .full,
		.pop(cq_pop), .rdata(bcmd_bits), .empty(cq_empty)
	);
	assign bcmd = cmd_t'(bcmd_bits);

	pgse_back u_back (
		.clk, .arst_n, .cmd_avail(!cq_empty), .cmd(bcmd), .cmd_pop(cq_pop),
		.out_full(ob_full), .out_push(ob_push), .out_item(bitem)
	);

	pgse_fifo #(.W(OBYTE_W), .DEPTH(4)) u_oq (
		.clk, .arst_n, .push(ob_push), .wdata(bitem), .full(ob_full),
		.pop, .rdata(oitem_bits), .empty
	);
	assign oitem        = obyte_t'(oitem_bits);
	assign out_byte     = oitem.data;
	assign last_of_run  = oitem.last;
	assign end_of_image = oitem.eoi;

	a_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		ob_push |-> !ob_full) else $error("output queue overrun");
	a_cmd_pop: assert property (@(posedge clk) disable iff (!arst_n)
		cq_pop |-> !cq_empty) else $error("command queue underrun");
	a_eoi_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && end_of_image) |-> last_of_run) else $error("end without run end");
endmodule

/* rtl/pgse_fifo.sv */
// Small synchronous queue used between the front, the sequencer and the output.
// Depends on nothing; DEPTH must be a power of two.
`timescale 1ns / 1ps
module pgse_fifo #(
	parameter int W = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wp_q <= wp_q + AW'(1);
			if (do_pop)
				rp_q <= rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
		end
	end
endmodule

/* rtl/pgse_front.sv */
// Front end: configuration registers, size latching, row/column framing.
// Classifies each pixel into a command for the sequencer; uses pgse_pkg.
`timescale 1ns / 1ps
module pgse_front #(
	parameter int MAX_WIDTH = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [12:0]           cfg_data,
	input  logic                  accept,
	input  logic [7:0]            pixel,
	output logic                  enq,
	output pgse_pkg::cmd_t        cmd
);
	import pgse_pkg::*;

	logic [DIM_W-1:0] img_width_q, img_height_q, w_q, h_q;
	logic [DIM_W-1:0] col_q, row_q, w_cl, h_cl, cur_w, cur_h;
	logic             started_q, done_q, tailpend_q;
	logic             end_row, end_img;

	// zero reads as one, oversize clips to the maximum
	always_comb begin
		if (img_width_q == '0)
			w_cl = DIM_W'(1);
		else if (32'(img_width_q) > MAX_WIDTH)
			w_cl = DIM_W'(MAX_WIDTH);
		else
			w_cl = img_width_q;
		if (img_height_q == '0)
			h_cl = DIM_W'(1);
		else if (32'(img_height_q) > MAX_HEIGHT)
			h_cl = DIM_W'(MAX_HEIGHT);
		else
			h_cl = img_height_q;
	end

	assign cur_w   = started_q ? w_q : w_cl;
	assign cur_h   = started_q ? h_q : h_cl;
	assign end_row = (col_q + DIM_W'(1)) == cur_w;
	assign end_img = end_row && ((row_q + DIM_W'(1)) == cur_h);
	assign enq     = accept && (!done_q || tailpend_q);

	always_comb begin
		cmd.pix   = pixel;
		cmd.first = !started_q;
		cmd.col0  = (col_q == '0);
		cmd.last  = end_img;
		cmd.tail  = done_q;
		cmd.w     = cur_w;
		cmd.h     = cur_h;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_width_q  <= 13'd128;
			img_height_q <= 13'd64;
			w_q          <= DIM_W'(1);
			h_q          <= DIM_W'(1);
			col_q        <= '0;
			row_q        <= '0;
			started_q    <= 1'b0;
			done_q       <= 1'b0;
			tailpend_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index)
					img_height_q <= cfg_data;
				else
					img_width_q <= cfg_data;
			end
			if (accept) begin
				if (done_q) begin
					tailpend_q <= 1'b0;
				end else begin
					if (!started_q) begin
						w_q       <= w_cl;
						h_q       <= h_cl;
						started_q <= 1'b1;
					end
					if (end_row) begin
						col_q <= '0;
						row_q <= row_q + DIM_W'(1);
					end else begin
						col_q <= col_q + DIM_W'(1);
					end
					if (end_img) begin
						done_q     <= 1'b1;
						// only a 1x1 image overruns the burst limit
						tailpend_q <= !started_q;
					end
				end
			end
		end
	end
endmodule

/* rtl/pgse_back.sv */
// Byte sequencer: emits header, stored-block framing, raw data and trailer,
// keeping chunk CRC-32 and Adler-32. Uses pgse_pkg.
`timescale 1ns / 1ps
module pgse_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_avail,
	input  pgse_pkg::cmd_t        cmd,
	output logic                  cmd_pop,
	input  logic                  out_full,
	output logic                  out_push,
	output pgse_pkg::obyte_t      out_item
);
	import pgse_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_HDR, S_RAW, S_TAIL} state_t;

	state_t           state_q;
	logic [5:0]       hidx_q, run_q;
	logic [4:0]       tidx_q;
	logic [2:0]       bh_q;
	logic             bhdone_q, filt_q, last_q;
	logic [7:0]       pix_q;
	logic [DIM_W-1:0] w_q, h_q;
	logic [RAW_W-1:0] raw_s1, rem_q;
	logic [31:0]      idat_s2, crc_q, crc_inv, adler;
	logic [15:0]      fill_q, alo_q, ahi_q, bn;
	logic [7:0]       byte_c, raw_b;
	logic             crc_on, crc_rst, fin_c, eoi_c, hdr_need, go;
	logic [16:0]      lo_s, hi_s;
	logic [15:0]      lo_n, hi_n;
	logic [9:0]       q0;
	logic [16:0]      r0;
	logic             corr;
	logic [10:0]      blocks;

	assign go       = (state_q != S_IDLE) && !out_full;
	assign cmd_pop  = (state_q == S_IDLE) && cmd_avail;
	assign crc_inv  = ~crc_q;
	assign adler    = {ahi_q, alo_q};
	assign hdr_need = (fill_q == '0) && !bhdone_q;
	assign bn       = (rem_q > RAW_W'(BLOCK_MAX)) ? BLOCK_MAX : rem_q[15:0];
	assign raw_b    = filt_q ? 8'h00 : pix_q;

	// IDAT length = 6 + raw + 5 * ceil(raw / 65535)
	always_comb begin
		q0     = raw_s1[25:16];
		r0     = {1'b0, raw_s1[15:0]} + 17'(q0);
		corr   = r0 >= {1'b0, BLOCK_MAX};
		blocks = 11'(q0) + 11'(corr)
			+ 11'((corr ? (r0 - {1'b0, BLOCK_MAX}) : r0) != '0);
	end

	always_comb begin
		lo_s = {1'b0, alo_q} + 17'(raw_b);
		lo_n = (lo_s >= ADLER_MOD) ? 16'(lo_s - ADLER_MOD) : lo_s[15:0];
		hi_s = {1'b0, ahi_q} + {1'b0, lo_n};
		hi_n = (hi_s >= ADLER_MOD) ? 16'(hi_s - ADLER_MOD) : hi_s[15:0];
	end

	always_comb begin
		byte_c  = 8'h00;
		crc_on  = 1'b0;
		crc_rst = 1'b0;
		fin_c   = 1'b0;
		eoi_c   = 1'b0;
		unique case (state_q)
			S_HDR: begin
				crc_on  = ((hidx_q >= HDR_IHDR_TYPE) && (hidx_q <= HDR_IHDR_END))
					|| (hidx_q >= HDR_IDAT_TYPE);
				crc_rst = (hidx_q == HDR_IHDR_TYPE) || (hidx_q == HDR_IDAT_TYPE);
				if (hidx_q == 6'd18)
					byte_c = {3'd0, w_q[12:8]};
				else if (hidx_q == 6'd19)
					byte_c = w_q[7:0];
				else if (hidx_q == 6'd22)
					byte_c = {3'd0, h_q[12:8]};
				else if (hidx_q == 6'd23)
					byte_c = h_q[7:0];
				else if ((hidx_q >= HDR_CRC0) && (hidx_q < HDR_LEN0))
					byte_c = crc_inv[8*(3-(hidx_q-HDR_CRC0)) +: 8];
				else if ((hidx_q >= HDR_LEN0) && (hidx_q < HDR_IDAT_TYPE))
					byte_c = idat_s2[8*(3-(hidx_q-HDR_LEN0)) +: 8];
				else
					byte_c = hdr_const(hidx_q);
			end
			S_RAW: begin
				crc_on = 1'b1;
				if (hdr_need) begin
					unique case (bh_q)
						3'd0: byte_c = {7'd0, rem_q <= RAW_W'(BLOCK_MAX)};
						3'd1: byte_c = bn[7:0];
						3'd2: byte_c = bn[15:8];
						3'd3: byte_c = ~bn[7:0];
						default: byte_c = ~bn[15:8];
					endcase
				end else begin
					byte_c = raw_b;
					fin_c  = !filt_q && !last_q;
				end
			end
			S_TAIL: begin
				crc_on  = (tidx_q < TL_CRC0) ||
					((tidx_q >= TL_IEND_TYPE) && (tidx_q < TL_CRC1));
				crc_rst = (tidx_q == TL_IEND_TYPE);
				fin_c   = (tidx_q == TL_LAST);
				eoi_c   = fin_c;
				if (tidx_q < TL_CRC0)
					byte_c = adler[8*(3-tidx_q[1:0]) +: 8];
				else if (tidx_q < TL_IEND_LEN)
					byte_c = crc_inv[8*(3-tidx_q[1:0]) +: 8];
				else if (tidx_q < TL_IEND_TYPE)
					byte_c = 8'h00;
				else if (tidx_q < TL_CRC1)
					byte_c = iend_type(tidx_q[1:0]);
				else
					byte_c = crc_inv[8*(3-tidx_q[1:0]) +: 8];
			end
			default: ;
		endcase
	end

	assign out_push      = go;
	assign out_item.data = byte_c;
	assign out_item.last = fin_c || (run_q == RUN_LAST);
	assign out_item.eoi  = eoi_c;

	always_ff @(posedge clk) begin
		raw_s1  <= RAW_W'(h_q) * RAW_W'({1'b0, w_q} + 14'd1);
		idat_s2 <= 32'd6 + 32'(raw_s1) + 32'(blocks) * 32'd5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			hidx_q   <= '0;
			tidx_q   <= '0;
			run_q    <= '0;
			bh_q     <= '0;
			bhdone_q <= 1'b0;
			filt_q   <= 1'b0;
			last_q   <= 1'b0;
			pix_q    <= '0;
			w_q      <= DIM_W'(1);
			h_q      <= DIM_W'(1);
			rem_q    <= '0;
			fill_q   <= '0;
			alo_q    <= 16'd1;
			ahi_q    <= '0;
			crc_q    <= CRC_INIT;
		end else begin
			if (cmd_pop) begin
				run_q  <= '0;
				pix_q  <= cmd.pix;
				filt_q <= cmd.col0;
				last_q <= cmd.last;
				if (cmd.tail) begin
					state_q <= S_TAIL;
				end else if (cmd.first) begin
					state_q <= S_HDR;
					hidx_q  <= '0;
					w_q     <= cmd.w;
					h_q     <= cmd.h;
					fill_q  <= '0;
					alo_q   <= 16'd1;
					ahi_q   <= '0;
				end else begin
					state_q <= S_RAW;
				end
			end
			if (go) begin
				run_q <= run_q + 6'd1;
				if (crc_on)
					crc_q <= crc_byte(crc_rst ? CRC_INIT : crc_q, byte_c);
				unique case (state_q)
					S_HDR: begin
						hidx_q <= hidx_q + 6'd1;
						if (hidx_q == HDR_LAST) begin
							state_q <= S_RAW;
							rem_q   <= raw_s1;
						end
					end
					S_RAW: begin
						if (hdr_need) begin
							if (bh_q == 3'd4) begin
								bh_q     <= '0;
								bhdone_q <= 1'b1;
							end else begin
								bh_q <= bh_q + 3'd1;
							end
						end else begin
							bhdone_q <= 1'b0;
							alo_q    <= lo_n;
							ahi_q    <= hi_n;
							fill_q   <= (fill_q == BLOCK_MAX - 16'd1) ? '0 : fill_q + 16'd1;
							if (rem_q != '0)
								rem_q <= rem_q - RAW_W'(1);
							if (filt_q) begin
								filt_q <= 1'b0;
							end else if (last_q) begin
								state_q <= S_TAIL;
								tidx_q  <= '0;
							end else begin
								state_q <= S_IDLE;
							end
						end
					end
					S_TAIL: begin
						tidx_q <= tidx_q + 5'd1;
						// end of image or burst limit reached: go idle; after the burst limit the next pixel resumes
						if (fin_c || (run_q == RUN_LAST))
							state_q <= S_IDLE;
					end
					default: ;
				endcase
			end
		end
	end
endmodule
